>>> sv/console_line_discipline_macros.svh
// ----------------------------------------------------------------------------
// console_line_discipline_macros.svh
// Assertion helpers for the console line discipline. The checks are
// clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_DISCIPLINE_MACROS_SVH
`define CONSOLE_LINE_DISCIPLINE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CLD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line discipline check failed");

// next-cycle implication
`define CLD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line discipline check failed");

`else

`define CLD_ASSERT_NOW(lbl, ante, cons)
`define CLD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg
// Shared constants, types and pointer helpers for the console line discipline.
// ----------------------------------------------------------------------------
`default_nettype none

package cld_pkg;

	// ring geometry; pointers count modulo twice the depth
	localparam int BUFFER_DEPTH = 128;
	localparam int PTR_SPAN     = 2 * BUFFER_DEPTH;
	localparam int PTR_W        = $clog2(PTR_SPAN);
	localparam int SLOT_W       = $clog2(BUFFER_DEPTH);

	// register port
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;
	localparam logic [ADDR_W-3:0] REG_CR_MAP = '0;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [SLOT_W-1:0] slot_t;

	// character codes
	localparam logic [7:0] KEY_NUL    = 8'h00;
	localparam logic [7:0] KEY_CTRL_B = 8'h02;
	localparam logic [7:0] KEY_CTRL_D = 8'h04;
	localparam logic [7:0] KEY_CTRL_E = 8'h05;
	localparam logic [7:0] KEY_CTRL_H = 8'h08;
	localparam logic [7:0] KEY_NL     = 8'h0A;
	localparam logic [7:0] KEY_CTRL_K = 8'h0B;
	localparam logic [7:0] KEY_CR     = 8'h0D;
	localparam logic [7:0] KEY_CTRL_P = 8'h10;
	localparam logic [7:0] KEY_CTRL_Q = 8'h11;
	localparam logic [7:0] KEY_CTRL_U = 8'h15;
	localparam logic [7:0] KEY_DEL    = 8'h7F;

	// action codes
	localparam logic ACT_KEY  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// dump request codes
	localparam logic [2:0] DUMP_NONE  = 3'd0;
	localparam logic [2:0] DUMP_PROC  = 3'd1;
	localparam logic [2:0] DUMP_FILES = 3'd2;
	localparam logic [2:0] DUMP_ALLOC = 3'd3;
	localparam logic [2:0] DUMP_BUFS  = 3'd4;
	localparam logic [2:0] DUMP_PHYS  = 3'd5;

	// one result word
	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_char;
		logic [7:0] erase_count;
		logic       line_ready;
		logic [2:0] dump_request;
		logic       read_empty;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       read_end;
	} res_t;

	// line store access
	typedef struct packed {
		logic       we;
		slot_t      waddr;
		logic [7:0] wdata;
		logic       re;
		slot_t      raddr;
	} mem_req_t;

	function automatic ptr_t ptr_inc(ptr_t p);
		return (p == ptr_t'(PTR_SPAN - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic ptr_t ptr_dec(ptr_t p);
		return (p == '0) ? ptr_t'(PTR_SPAN - 1) : p - ptr_t'(1);
	endfunction

	function automatic slot_t ptr_slot(ptr_t p);
		return (p >= ptr_t'(BUFFER_DEPTH)) ? SLOT_W'(p - ptr_t'(BUFFER_DEPTH))
			: SLOT_W'(p);
	endfunction

	// a - b modulo the pointer span
	function automatic ptr_t ptr_dist(ptr_t a, ptr_t b);
		logic [PTR_W:0] wide;
		wide = {1'b0, a} + (PTR_W + 1)'(PTR_SPAN) - {1'b0, b};
		return (a >= b) ? a - b : wide[PTR_W-1:0];
	endfunction

	function automatic logic [7:0] sat8(ptr_t n);
		logic [PTR_W+7:0] wide;
		wide = (PTR_W + 8)'(n);
		return (wide > (PTR_W + 8)'(255)) ? 8'hFF : wide[7:0];
	endfunction

	function automatic logic [2:0] dump_code(logic [7:0] c);
		logic [2:0] d;
		unique case (c)
			KEY_CTRL_P: d = DUMP_PROC;
			KEY_CTRL_E: d = DUMP_FILES;
			KEY_CTRL_K: d = DUMP_ALLOC;
			KEY_CTRL_B: d = DUMP_BUFS;
			KEY_CTRL_Q: d = DUMP_PHYS;
			default:    d = DUMP_NONE;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

>>> sv/console_line_discipline.sv
// A word is accepted in ST_IDLE; its result is registered in ST_EXEC once the
//   output is free, and out_valid rises with it.
// A new word is not taken until the last one's pointer update is done, after the
//   line store's registered read; a held result stalls the update.
// Reset (arst_n low, asynchronous): read, commit and edit pointers go to zero,
//   cr_maps_to_newline goes to 1; the line store is not cleared.
// ----------------------------------------------------------------------------
// console_line_discipline
// Canonical console line editor on a ring buffer with read, commit and edit
// pointers, a line store memory and an APB-style register port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "console_line_discipline_macros.svh"

module console_line_discipline (
	input  wire                          clk,
	input  wire                          arst_n,

	// APB-style register port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [cld_pkg::ADDR_W-1:0]   paddr,
	input  wire  [cld_pkg::DATA_W-1:0]   pwdata,
	output logic [cld_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,

	// input words
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          action,
	input  wire  [7:0]                   key,
	input  wire                          read_started,

	// result words
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         echo_valid,
	output logic [7:0]                   echo_char,
	output logic [7:0]                   erase_count,
	output logic                         line_ready,
	output logic [2:0]                   dump_request,
	output logic                         read_empty,
	output logic                         read_valid,
	output logic [7:0]                   read_byte,
	output logic                         read_end
);
	import cld_pkg::*;

	logic     cr_map_q;
	logic     reg_sel;
	mem_req_t mem_req;
	logic [7:0] mem_rdata;
	res_t     res;

	// ---------------------------------------------------------------------
	// Register port. Only cr_maps_to_newline exists, at byte address 0;
	// pready is tied high so every access completes in its access cycle.
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_CR_MAP);
	assign prdata  = reg_sel ? DATA_W'(cr_map_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_map_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cr_map_q <= pwdata[0];
		end
	end

	// ---------------------------------------------------------------------
	// Line store: written by stored keys, read once per accepted word at the
	// read pointer's slot. Accesses are spaced by the editor's idle/execute
	// sequence, so a read never meets a write to the same slot in flight.
	// ---------------------------------------------------------------------
	cld_line_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// ---------------------------------------------------------------------
	// Editor: decodes the word, moves the pointers and holds the result.
	// ---------------------------------------------------------------------
	cld_editor u_editor (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.key          (key),
		.read_started (read_started),
		.cr_map       (cr_map_q),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.res          (res)
	);

	assign echo_valid   = res.echo_valid;
	assign echo_char    = res.echo_char;
	assign erase_count  = res.erase_count;
	assign line_ready   = res.line_ready;
	assign dump_request = res.dump_request;
	assign read_empty   = res.read_empty;
	assign read_valid   = res.read_valid;
	assign read_byte    = res.read_byte;
	assign read_end     = res.read_end;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	// one word in flight: no accept in the cycle after an accept
	`CLD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// the store is written only while a word is being executed
	`CLD_ASSERT_NOW(a_write_not_idle, mem_req.we, !in_ready && !mem_req.re)
	// a committed line always comes with the stored character echoed
	`CLD_ASSERT_NOW(a_commit_echoes, out_valid && line_ready, echo_valid && !read_valid)

endmodule

`default_nettype wire

>>> sv/cld_line_ram.sv
// ----------------------------------------------------------------------------
// cld_line_ram
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_line_ram (
	input  wire               clk,
	input  cld_pkg::mem_req_t req,
	output logic [7:0]        rdata
);
	import cld_pkg::*;

	logic [7:0] mem [BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/cld_editor.sv
// ----------------------------------------------------------------------------
// cld_editor
// Pointer state, key/read decode, line store access and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_editor (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               action,
	input  wire  [7:0]        key,
	input  wire               read_started,
	input  wire               cr_map,
	output cld_pkg::mem_req_t mem_req,
	input  wire  [7:0]        mem_rdata,
	output logic              out_valid,
	input  wire               out_ready,
	output cld_pkg::res_t     res
);
	import cld_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t     state_q;
	ptr_t       rd_q, cm_q, ed_q;
	logic       action_s1;
	logic [7:0] key_s1;
	logic       started_s1;
	res_t       res_q;
	logic       out_valid_q;

	logic       accept, out_free, exec;
	ptr_t       rd_n, cm_n, ed_n, ed_inc;
	res_t       res_n;
	logic [7:0] ch;
	logic [2:0] dump;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign exec      = (state_q == ST_EXEC) && out_free;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign dump   = dump_code(key_s1);
	assign ed_inc = ptr_inc(ed_q);
	assign ch     = (key_s1 == KEY_CR) ? KEY_NL : key_s1;

	always_comb begin
		rd_n          = rd_q;
		cm_n          = cm_q;
		ed_n          = ed_q;
		res_n         = '0;
		mem_req       = '0;
		// read the slot at the read pointer as the item comes in
		mem_req.re    = accept;
		mem_req.raddr = ptr_slot(rd_q);
		mem_req.waddr = ptr_slot(ed_q);
		mem_req.wdata = ch;

		if (action_s1 == ACT_KEY) begin
			if (dump != DUMP_NONE) begin
				res_n.dump_request = dump;
			end else if (key_s1 == KEY_CTRL_U) begin
				// the uncommitted tail never holds a newline: a newline commits
				res_n.erase_count = sat8(ptr_dist(ed_q, cm_q));
				ed_n = cm_q;
			end else if (key_s1 == KEY_CTRL_H || key_s1 == KEY_DEL) begin
				if (ed_q != cm_q) begin
					ed_n = ptr_dec(ed_q);
					res_n.erase_count = 8'd1;
				end
			end else if (key_s1 == KEY_NUL ||
					ptr_dist(ed_q, rd_q) >= ptr_t'(BUFFER_DEPTH)) begin
				// ignored
			end else if (key_s1 == KEY_CR && !cr_map) begin
				// dropped
			end else begin
				res_n.echo_valid = 1'b1;
				res_n.echo_char  = ch;
				mem_req.we       = exec;
				ed_n             = ed_inc;
				if (ch == KEY_NL || ch == KEY_CTRL_D ||
						ptr_dist(ed_inc, rd_q) == ptr_t'(BUFFER_DEPTH)) begin
					cm_n = ed_inc;
					res_n.line_ready = 1'b1;
				end
			end
		end else begin
			if (rd_q == cm_q) begin
				res_n.read_empty = 1'b1;
			end else if (mem_rdata == KEY_CTRL_D) begin
				// end of file stays for the next read if bytes went out already
				if (!started_s1) begin
					rd_n = ptr_inc(rd_q);
				end
				res_n.read_end = 1'b1;
			end else begin
				rd_n             = ptr_inc(rd_q);
				res_n.read_valid = 1'b1;
				res_n.read_byte  = mem_rdata;
				res_n.read_end   = (mem_rdata == KEY_NL);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_q        <= '0;
			cm_q        <= '0;
			ed_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						rd_q    <= rd_n;
						cm_q    <= cm_n;
						ed_q    <= ed_n;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action;
			key_s1     <= key;
			started_s1 <= read_started;
		end
		if (exec) begin
			res_q <= res_n;
		end
	end

endmodule

`default_nettype wire
